[rtl/yrgb_pkg.sv]
`timescale 1ns / 1ps

package yrgb_pkg;

  localparam int COEF_FRAC_BITS = 12;

  localparam int PIX_W  = 8;
  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int OFS_W  = COEF_FRAC_BITS + 9;
  localparam int PROD_W = COEF_W + PIX_W;
  localparam int ACC_W  = COEF_FRAC_BITS + 12;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic [COEF_W-1:0]        coef_t;
  typedef logic [OFS_W-1:0]         ofs_t;
  typedef logic [PROD_W-1:0]        prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // coefficient in millionths, times 255 and 2^F, rounded to nearest
  function automatic logic [63:0] scaled(input logic [63:0] millionths);
    return (millionths * 64'd255 * (64'd1 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
  endfunction

  localparam coef_t K_Y  = COEF_W'(scaled(64'd4565));
  localparam coef_t K_RU = COEF_W'(scaled(64'd1));
  localparam coef_t K_RV = COEF_W'(scaled(64'd6250));
  localparam coef_t K_GU = COEF_W'(scaled(64'd1542));
  localparam coef_t K_GV = COEF_W'(scaled(64'd3183));
  localparam coef_t K_BU = COEF_W'(scaled(64'd7935));
  localparam ofs_t  K_R0 = OFS_W'(scaled(64'd872000));
  localparam ofs_t  K_G0 = OFS_W'(scaled(64'd531000));
  localparam ofs_t  K_B0 = OFS_W'(scaled(64'd1088000));

  localparam acc_t CLAMP_TOP = acc_t'(255) <<< COEF_FRAC_BITS;

  typedef struct packed {
    pix_t y1;
    pix_t u;
    pix_t y2;
    pix_t v;
  } yuyv_t;

  typedef struct packed {
    prod_t py1;
    prod_t py2;
    prod_t pru;
    prod_t prv;
    prod_t pgu;
    prod_t pgv;
    prod_t pbu;
  } prod_set_t;

  typedef struct packed {
    prod_t py1;
    prod_t py2;
    acc_t  cr;
    acc_t  cg;
    acc_t  cb;
  } term_set_t;

  typedef struct packed {
    acc_t r1;
    acc_t g1;
    acc_t b1;
    acc_t r2;
    acc_t g2;
    acc_t b2;
  } sum_set_t;

  typedef struct packed {
    pix_t b2;
    pix_t g2;
    pix_t r2;
    pix_t b1;
    pix_t g1;
    pix_t r1;
  } rgb_pair_t;

endpackage

[rtl/yrgb_mul_stage.sv]
`timescale 1ns / 1ps

module yrgb_mul_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  yrgb_pkg::yuyv_t      in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output yrgb_pkg::prod_set_t  out_data
);

  logic                 a_valid_r;
  yrgb_pkg::yuyv_t      a_data_r;
  logic                 a_ready;
  logic                 b_valid_r;
  yrgb_pkg::prod_set_t  b_data_r;
  yrgb_pkg::prod_set_t  b_data_nxt;
  logic                 b_ready;

  assign b_ready  = !b_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_data_r <= in_data;
    end
  end

  always_comb begin
    b_data_nxt.py1 = yrgb_pkg::prod_t'(yrgb_pkg::K_Y)  * yrgb_pkg::prod_t'(a_data_r.y1);
    b_data_nxt.py2 = yrgb_pkg::prod_t'(yrgb_pkg::K_Y)  * yrgb_pkg::prod_t'(a_data_r.y2);
    b_data_nxt.pru = yrgb_pkg::prod_t'(yrgb_pkg::K_RU) * yrgb_pkg::prod_t'(a_data_r.u);
    b_data_nxt.prv = yrgb_pkg::prod_t'(yrgb_pkg::K_RV) * yrgb_pkg::prod_t'(a_data_r.v);
    b_data_nxt.pgu = yrgb_pkg::prod_t'(yrgb_pkg::K_GU) * yrgb_pkg::prod_t'(a_data_r.u);
    b_data_nxt.pgv = yrgb_pkg::prod_t'(yrgb_pkg::K_GV) * yrgb_pkg::prod_t'(a_data_r.v);
    b_data_nxt.pbu = yrgb_pkg::prod_t'(yrgb_pkg::K_BU) * yrgb_pkg::prod_t'(a_data_r.u);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_data  = b_data_r;

endmodule

[rtl/yrgb_add_stage.sv]
`timescale 1ns / 1ps

module yrgb_add_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  yrgb_pkg::prod_set_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output yrgb_pkg::sum_set_t   out_data
);

  logic                 c_valid_r;
  yrgb_pkg::term_set_t  c_data_r;
  yrgb_pkg::term_set_t  c_data_nxt;
  logic                 c_ready;
  logic                 d_valid_r;
  yrgb_pkg::sum_set_t   d_data_r;
  yrgb_pkg::sum_set_t   d_data_nxt;
  logic                 d_ready;
  yrgb_pkg::acc_t       y1_acc;
  yrgb_pkg::acc_t       y2_acc;

  assign d_ready  = !d_valid_r || out_ready;
  assign c_ready  = !c_valid_r || d_ready;
  assign in_ready = c_ready;

  // fold the chroma products and offsets into one term per channel
  always_comb begin
    c_data_nxt.py1 = in_data.py1;
    c_data_nxt.py2 = in_data.py2;
    c_data_nxt.cr  = yrgb_pkg::acc_t'(in_data.pru) + yrgb_pkg::acc_t'(in_data.prv)
                   - yrgb_pkg::acc_t'(yrgb_pkg::K_R0);
    c_data_nxt.cg  = yrgb_pkg::acc_t'(yrgb_pkg::K_G0) - yrgb_pkg::acc_t'(in_data.pgu)
                   - yrgb_pkg::acc_t'(in_data.pgv);
    c_data_nxt.cb  = yrgb_pkg::acc_t'(in_data.pbu) - yrgb_pkg::acc_t'(yrgb_pkg::K_B0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_ready) begin
      c_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && in_valid) begin
      c_data_r <= c_data_nxt;
    end
  end

  always_comb begin
    y1_acc        = yrgb_pkg::acc_t'(c_data_r.py1);
    y2_acc        = yrgb_pkg::acc_t'(c_data_r.py2);
    d_data_nxt.r1 = y1_acc + c_data_r.cr;
    d_data_nxt.g1 = y1_acc + c_data_r.cg;
    d_data_nxt.b1 = y1_acc + c_data_r.cb;
    d_data_nxt.r2 = y2_acc + c_data_r.cr;
    d_data_nxt.g2 = y2_acc + c_data_r.cg;
    d_data_nxt.b2 = y2_acc + c_data_r.cb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (d_ready) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid_r) begin
      d_data_r <= d_data_nxt;
    end
  end

  assign out_valid = d_valid_r;
  assign out_data  = d_data_r;

endmodule

[rtl/yrgb_clamp_stage.sv]
`timescale 1ns / 1ps

module yrgb_clamp_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  yrgb_pkg::sum_set_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output yrgb_pkg::rgb_pair_t  out_data
);

  logic                 e_valid_r;
  yrgb_pkg::rgb_pair_t  e_data_r;
  yrgb_pkg::rgb_pair_t  e_data_nxt;
  logic                 e_ready;

  function automatic yrgb_pkg::pix_t clamp_ch(input yrgb_pkg::acc_t acc);
    yrgb_pkg::pix_t res;
    if (acc < 0) begin
      res = '0;
    end else if (acc >= yrgb_pkg::CLAMP_TOP) begin
      res = '1;
    end else begin
      res = acc[yrgb_pkg::COEF_FRAC_BITS +: yrgb_pkg::PIX_W];
    end
    return res;
  endfunction

  assign e_ready  = !e_valid_r || out_ready;
  assign in_ready = e_ready;

  always_comb begin
    e_data_nxt.r1 = clamp_ch(in_data.r1);
    e_data_nxt.g1 = clamp_ch(in_data.g1);
    e_data_nxt.b1 = clamp_ch(in_data.b1);
    e_data_nxt.r2 = clamp_ch(in_data.r2);
    e_data_nxt.g2 = clamp_ch(in_data.g2);
    e_data_nxt.b2 = clamp_ch(in_data.b2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (e_ready) begin
      e_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready && in_valid) begin
      e_data_r <= e_data_nxt;
    end
  end

  assign out_valid = e_valid_r;
  assign out_data  = e_data_r;

endmodule

[rtl/yuyv_to_rgb_pixel_pair_top.sv]
`timescale 1ns / 1ps
// Inputs pass through stage registers a, b (mul), c, d (add) and e (clamp) in turn.
// Throughput: one YUYV group per cycle while out_tready is high; five register stages.
// A stalled output fills the pipeline; empty stages keep taking input until it is full.
// Reset (rst_n low, synchronous) clears all stage valid bits but not the data registers.

module yuyv_to_rgb_pixel_pair_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // luma_first, chroma_blue, luma_second, chroma_red
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // red_first, green_first, blue_first,
                                  // red_second, green_second, blue_second
);

  yrgb_pkg::yuyv_t      in_group;
  logic                 mul_valid;
  logic                 mul_ready;
  yrgb_pkg::prod_set_t  mul_data;
  logic                 add_valid;
  logic                 add_ready;
  yrgb_pkg::sum_set_t   add_data;
  yrgb_pkg::rgb_pair_t  rgb_data;

  assign in_group.y1 = in_tdata[7:0];
  assign in_group.u  = in_tdata[15:8];
  assign in_group.y2 = in_tdata[23:16];
  assign in_group.v  = in_tdata[31:24];

  yrgb_mul_stage u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_group),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_data  (mul_data)
  );

  yrgb_add_stage u_add (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_data   (mul_data),
    .out_valid (add_valid),
    .out_ready (add_ready),
    .out_data  (add_data)
  );

  yrgb_clamp_stage u_clamp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (add_valid),
    .in_ready  (add_ready),
    .in_data   (add_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (rgb_data)
  );

  assign out_tdata = {rgb_data.b2, rgb_data.g2, rgb_data.r2,
                      rgb_data.b1, rgb_data.g1, rgb_data.r1};

endmodule
